### sv/physical_frame_table_unit_macros.svh
// Assertion macros of the frame table, used by its top-level unit.
`ifndef PHYSICAL_FRAME_TABLE_UNIT_MACROS_SVH
`define PHYSICAL_FRAME_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pft_pkg.sv
// Package of the frame table: field widths, operation and status codes, shared types.
`default_nettype none

package pft_pkg;

    localparam int FUNC_W  = 3;
    localparam int FRAME_W = 5;
    localparam int PAGE_W  = 16;
    localparam int PID_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;

    // Number of used bits examined by the scan unit in one cycle.
    localparam int SCAN_CHUNK = 8;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_MARK    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COUNT   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_VICTIM  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic done;
        logic found;
    } scan_flags_t;

endpackage

`default_nettype wire

### sv/pft_ifs.sv
// Request and response channel interfaces of the frame table.
`default_nettype none

interface pft_req_if;
    import pft_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0]  func;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [PID_W-1:0]   owner;
    logic [PID_W-1:0]   requester;

    modport source (output valid, output func, output frame, output page,
                    output owner, output requester, input ready);
    modport sink   (input valid, input func, input frame, input page,
                    input owner, input requester, output ready);
endinterface

interface pft_rsp_if;
    import pft_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_out;
    logic               used_out;
    logic [PAGE_W-1:0]  page_out;
    logic [PID_W-1:0]   owner_out;
    logic [COUNT_W-1:0] free_count;

    modport source (output valid, output status, output frame_out, output used_out,
                    output page_out, output owner_out, output free_count, input ready);
    modport sink   (input valid, input status, input frame_out, input used_out,
                    input page_out, input owner_out, input free_count, output ready);
endinterface

`default_nettype wire

### sv/pft_store.sv
// Page and owner store of the frame table: one write port, one registered read port.
`default_nettype none

module pft_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/pft_scan.sv
// Shared scan unit: walks the used bits a chunk per cycle, finds the lowest free frame and counts free ones.
`default_nettype none

module pft_scan #(
    parameter int FRAMES = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [FRAMES-1:0]                used,
    output pft_pkg::scan_flags_t             flags,
    output logic [$clog2(FRAMES)-1:0]        first_free,
    output logic [$clog2(FRAMES+1)-1:0]      free_total
);
    import pft_pkg::*;

    localparam int CH     = SCAN_CHUNK;
    localparam int NCH    = (FRAMES + CH - 1) / CH;
    localparam int CW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW   = NCH * CH;
    localparam int OFF_W  = $clog2(CH);
    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);

    logic [PADW-1:0]   pad;
    logic [CH-1:0]     chunk;
    logic              hit;
    logic [OFF_W-1:0]  off;
    logic [OFF_W:0]    pop;

    logic              run_reg;
    logic              done_reg;
    logic              found_reg;
    logic [CW-1:0]     chunk_reg;
    logic [FIDX_W-1:0] idx_reg;
    logic [CNT_W-1:0]  total_reg;

    // Bits past the last frame read as used, so they are never found or counted.
    always_comb
    begin
        pad = '1;
        pad[FRAMES-1:0] = used;
        chunk = pad[int'(chunk_reg) * CH +: CH];
        hit = 1'b0;
        off = '0;
        pop = '0;
        for (int i = CH - 1; i >= 0; i--)
        begin
            if (!chunk[i])
            begin
                hit = 1'b1;
                off = OFF_W'(i);
            end
            pop = pop + {{OFF_W{1'b0}}, ~chunk[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            chunk_reg <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                chunk_reg <= '0;
                found_reg <= 1'b0;
                total_reg <= '0;
            end
            else if (run_reg)
            begin
                total_reg <= CNT_W'(int'(total_reg) + int'(pop));
                if (hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                    idx_reg   <= FIDX_W'(int'(chunk_reg) * CH + int'(off));
                end
                if (chunk_reg == CW'(NCH - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    chunk_reg <= chunk_reg + 1'b1;
                end
            end
        end
    end

    assign flags.done  = done_reg;
    assign flags.found = found_reg;
    assign first_free  = idx_reg;
    assign free_total  = total_reg;

endmodule

`default_nettype wire

### sv/physical_frame_table_unit.sv
// Allocate and count pass through the scan state, in which eight used bits are examined per cycle;
// release and query pass through the read state for one registered store read; mark and victim go
// straight to the finish state. A new transaction is taken only once the previous result is
// registered and the block is idle again; the finish state waits while a response is still held.
// After reset the page and owner store is cleared entry by entry, and no request is taken meanwhile.
// Reset also frees every frame and sets the victim pointer to zero.
`default_nettype none
`include "physical_frame_table_unit_macros.svh"

module physical_frame_table_unit #(
    parameter int FRAMES    = 32,
    parameter int PAGE_BITS = 16,
    parameter int PID_BITS  = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    pft_req_if.sink   req,
    pft_rsp_if.source rsp
);
    import pft_pkg::*;

    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int DW     = PAGE_BITS + PID_BITS;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]    func_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [FIDX_W-1:0]    idx_reg;
    logic                 inrange_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PID_BITS-1:0]  owner_reg;
    logic [PID_BITS-1:0]  requester_reg;

    logic [FRAMES-1:0]    used_reg;
    logic [FIDX_W-1:0]    vp_reg, vp_next, vp_inc;
    logic [FIDX_W-1:0]    clr_reg;

    logic                 rsp_valid_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [FRAME_W-1:0]   frame_out_reg;
    logic                 used_out_reg;
    logic [PAGE_W-1:0]    page_out_reg;
    logic [PID_W-1:0]     owner_out_reg;
    logic [COUNT_W-1:0]   free_count_reg;

    logic                 req_fire;
    logic                 fin_fire;
    logic                 in_range;
    logic [FIDX_W-1:0]    in_idx;
    logic                 scan_start;

    scan_flags_t          scan_flags;
    logic [FIDX_W-1:0]    scan_idx;
    logic [CNT_W-1:0]     scan_total;

    logic                 mem_we;
    logic [FIDX_W-1:0]    mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [DW-1:0]        mem_rdata;
    logic [PAGE_BITS-1:0] rd_page;
    logic [PID_BITS-1:0]  rd_owner;

    logic [STAT_W-1:0]    res_status;
    logic [FRAME_W-1:0]   res_frame;
    logic                 res_used;
    logic [PAGE_W-1:0]    res_page;
    logic [PID_W-1:0]     res_owner;
    logic [COUNT_W-1:0]   res_count;
    logic                 set_en;
    logic                 clr_en;
    logic [FIDX_W-1:0]    upd_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign fin_fire  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp.ready);

    // Frames beyond the table map to entry zero, as their effect is suppressed anyway.
    assign in_range   = int'(req.frame) < FRAMES;
    assign in_idx     = in_range ? FIDX_W'(req.frame) : '0;
    assign scan_start = req_fire && (req.func == FN_ALLOC || req.func == FN_COUNT);

    pft_scan #(
        .FRAMES (FRAMES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .used       (used_reg),
        .flags      (scan_flags),
        .first_free (scan_idx),
        .free_total (scan_total)
    );

    pft_store #(
        .DEPTH (FRAMES),
        .AW    (FIDX_W),
        .DW    (DW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    assign rd_page  = mem_rdata[DW-1:PID_BITS];
    assign rd_owner = mem_rdata[PID_BITS-1:0];
    assign mem_re   = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == FIDX_W'(FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.func) inside
                        FN_ALLOC, FN_COUNT:   state_next = S_SCAN;
                        FN_RELEASE, FN_QUERY: state_next = S_READ;
                        default:              state_next = S_FINISH;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (scan_flags.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign vp_inc = (vp_reg == FIDX_W'(FRAMES - 1)) ? '0 : vp_reg + 1'b1;

    always_comb
    begin
        res_status = ST_OK;
        res_frame  = '0;
        res_used   = 1'b0;
        res_page   = '0;
        res_owner  = '0;
        res_count  = '0;
        set_en     = 1'b0;
        clr_en     = 1'b0;
        upd_idx    = idx_reg;
        vp_next    = vp_reg;
        unique case (func_reg)
            FN_ALLOC:
            begin
                if (scan_flags.found)
                begin
                    res_frame = FRAME_W'(scan_idx);
                    set_en    = 1'b1;
                    upd_idx   = scan_idx;
                end
                else
                begin
                    res_status = ST_NOFREE;
                end
            end
            FN_MARK:
            begin
                res_frame = frame_reg;
                set_en    = inrange_reg;
            end
            FN_RELEASE:
            begin
                res_frame = frame_reg;
                if (inrange_reg)
                begin
                    if (used_reg[idx_reg] && requester_reg != rd_owner)
                    begin
                        res_status = ST_REFUSED;
                    end
                    else
                    begin
                        clr_en = 1'b1;
                    end
                end
            end
            FN_QUERY:
            begin
                res_frame = frame_reg;
                if (inrange_reg)
                begin
                    res_used  = used_reg[idx_reg];
                    res_page  = PAGE_W'(rd_page);
                    res_owner = PID_W'(rd_owner);
                end
            end
            FN_COUNT:
            begin
                res_count = COUNT_W'(scan_total);
            end
            FN_VICTIM:
            begin
                vp_next   = vp_inc;
                res_frame = FRAME_W'(vp_inc);
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Store writes: zeroes during the clearing pass, otherwise the claim made by a finishing item.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = upd_idx;
        mem_wdata = {page_reg, owner_reg};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (fin_fire && set_en)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            vp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (fin_fire)
            begin
                vp_reg <= vp_next;
                if (set_en)
                begin
                    used_reg[upd_idx] <= 1'b1;
                end
                if (clr_en)
                begin
                    used_reg[upd_idx] <= 1'b0;
                end
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg      <= req.func;
            frame_reg     <= req.frame;
            idx_reg       <= in_idx;
            inrange_reg   <= in_range;
            page_reg      <= PAGE_BITS'(req.page);
            owner_reg     <= PID_BITS'(req.owner);
            requester_reg <= PID_BITS'(req.requester);
        end
        if (fin_fire)
        begin
            status_reg     <= res_status;
            frame_out_reg  <= res_frame;
            used_out_reg   <= res_used;
            page_out_reg   <= res_page;
            owner_out_reg  <= res_owner;
            free_count_reg <= res_count;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.frame_out  = frame_out_reg;
    assign rsp.used_out   = used_out_reg;
    assign rsp.page_out   = page_out_reg;
    assign rsp.owner_out  = owner_out_reg;
    assign rsp.free_count = free_count_reg;

    `PFT_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != S_IDLE, "request accepted but sequencer stayed idle")
    `PFT_ASSERT_NOW(a_alloc_takes_free, state_reg == S_FINISH && func_reg == FN_ALLOC && scan_flags.found, !used_reg[scan_idx], "allocate picked a frame already in use")
    `PFT_ASSERT_NOW(a_victim_in_range, 1'b1, int'(vp_reg) < FRAMES, "victim pointer beyond table")
    `PFT_ASSERT_NOW(a_count_in_range, state_reg == S_FINISH && func_reg == FN_COUNT, int'(scan_total) <= FRAMES, "free count exceeds table size")

endmodule

`default_nettype wire

### tb/sv/tb_physical_frame_table_unit.sv
// Self-checking testbench of the physical frame table: directed table, then random phases.
`timescale 1ns / 100ps

module tb_physical_frame_table_unit;
    import pft_pkg::*;

    localparam int N_FRAMES       = 32;
    localparam int IDLE_LIMIT     = 3000;
    localparam int PHASE_ITEMS    = 150;
    localparam int RANDOM_PHASES  = 13;
    localparam int HOLD_AFTER     = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;

    // Function codes that the block treats as no operation.
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    // Shapes of the random phases.
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   owner;
        logic [PID_W-1:0]   requester;
    } frame_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame_out;
        logic               used_out;
        logic [PAGE_W-1:0]  page_out;
        logic [PID_W-1:0]   owner_out;
        logic [COUNT_W-1:0] free_count;
    } frame_rsp_t;

    typedef struct {
        frame_req_t req;
        int         reps;
        bit         typed;
        frame_rsp_t rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pft_req_if frame_req();
    pft_rsp_if frame_rsp();

    physical_frame_table_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (frame_req),
        .rsp   (frame_rsp)
    );

    // Shadow copy of the frame table.
    bit                 shadow_used [N_FRAMES];
    logic [PAGE_W-1:0]  shadow_page [N_FRAMES];
    logic [PID_W-1:0]   shadow_owner[N_FRAMES];
    int                 shadow_victim;

    frame_rsp_t pending_rsp_q[$];
    int         mismatch_count;
    int         rsp_seen;
    int         idle_cycles;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic frame_req_t mk_req(logic [FUNC_W-1:0] f, logic [FRAME_W-1:0] fr,
                                          logic [PAGE_W-1:0] pg, logic [PID_W-1:0] ow,
                                          logic [PID_W-1:0] rq);
        frame_req_t r;
        r.func      = f;
        r.frame     = fr;
        r.page      = pg;
        r.owner     = ow;
        r.requester = rq;
        return r;
    endfunction

    function automatic frame_rsp_t mk_rsp(logic [STAT_W-1:0] st, logic [FRAME_W-1:0] fo,
                                          logic uo, logic [PAGE_W-1:0] po,
                                          logic [PID_W-1:0] oo, logic [COUNT_W-1:0] cnt);
        frame_rsp_t r;
        r.status     = st;
        r.frame_out  = fo;
        r.used_out   = uo;
        r.page_out   = po;
        r.owner_out  = oo;
        r.free_count = cnt;
        return r;
    endfunction

    function automatic dir_row_t mk_row(frame_req_t req, int reps, bit typed, frame_rsp_t rsp);
        dir_row_t row;
        row.req   = req;
        row.reps  = reps;
        row.typed = typed;
        row.rsp   = rsp;
        return row;
    endfunction

    // Applies one operation to the shadow table and returns the response it should give.
    function automatic frame_rsp_t apply_frame_op(frame_req_t r);
        frame_rsp_t res;
        bit         found;
        int         idx;
        int         n_free;
        res    = '0;
        found  = 1'b0;
        idx    = r.frame;
        n_free = 0;
        case (r.func)
            FN_ALLOC:
            begin
                res.status = ST_NOFREE;
                for (int i = 0; i < N_FRAMES; i++)
                begin
                    if (!found && !shadow_used[i])
                    begin
                        found           = 1'b1;
                        shadow_used[i]  = 1'b1;
                        shadow_page[i]  = r.page;
                        shadow_owner[i] = r.owner;
                        res.status      = ST_OK;
                        res.frame_out   = FRAME_W'(i);
                    end
                end
            end
            FN_MARK:
            begin
                res.frame_out     = r.frame;
                shadow_used[idx]  = 1'b1;
                shadow_page[idx]  = r.page;
                shadow_owner[idx] = r.owner;
            end
            FN_RELEASE:
            begin
                res.frame_out = r.frame;
                // A free frame may be released by anyone; a used one only by its owner.
                if (shadow_used[idx] && r.requester != shadow_owner[idx])
                    res.status = ST_REFUSED;
                else
                    shadow_used[idx] = 1'b0;
            end
            FN_QUERY:
            begin
                res.frame_out = r.frame;
                res.used_out  = shadow_used[idx];
                res.page_out  = shadow_page[idx];
                res.owner_out = shadow_owner[idx];
            end
            FN_COUNT:
            begin
                for (int i = 0; i < N_FRAMES; i++)
                    if (!shadow_used[i])
                        n_free++;
                res.free_count = COUNT_W'(n_free);
            end
            FN_VICTIM:
            begin
                shadow_victim = (shadow_victim + 1) % N_FRAMES;
                res.frame_out = FRAME_W'(shadow_victim);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        // A small pool of ids makes owner matches frequent.
        if ($urandom_range(0, 1) == 0)
            return PID_W'($urandom_range(0, 3));
        else
            return PID_W'($urandom_range(0, 255));
    endfunction

    function automatic frame_req_t draw_frame_op(int kind);
        frame_req_t r;
        int         sel;
        int         w_alloc;
        int         w_mark;
        r.frame     = FRAME_W'($urandom_range(0, N_FRAMES - 1));
        r.page      = PAGE_W'($urandom);
        r.owner     = pick_pid();
        r.requester = pick_pid();
        case (kind)
            PHASE_FILL:
            begin
                w_alloc = 45;
                w_mark  = 10;
            end
            PHASE_DRAIN:
            begin
                w_alloc = 10;
                w_mark  = 5;
            end
            default:
            begin
                w_alloc = 25;
                w_mark  = 15;
            end
        endcase
        sel = $urandom_range(0, 99);
        if (sel < w_alloc)
            r.func = FN_ALLOC;
        else if (sel < w_alloc + w_mark)
            r.func = FN_MARK;
        else if (sel < 65)
            r.func = FN_RELEASE;
        else if (sel < 77)
            r.func = FN_QUERY;
        else if (sel < 87)
            r.func = FN_COUNT;
        else if (sel < 97)
            r.func = FN_VICTIM;
        else
            r.func = ($urandom_range(0, 1) == 0) ? FN_SPARE_6 : FN_SPARE_7;
        if (r.func == FN_RELEASE && $urandom_range(0, 9) < 7)
            r.requester = shadow_owner[r.frame];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one transaction, waits for it to be taken and records what it should return.
    task automatic send_frame_op(input frame_req_t r, input bit typed,
                                 input frame_rsp_t typed_rsp, input bit no_gap);
        frame_rsp_t predicted;
        int         gap;
        frame_req.valid     = 1'b1;
        frame_req.func      = r.func;
        frame_req.frame     = r.frame;
        frame_req.page      = r.page;
        frame_req.owner     = r.owner;
        frame_req.requester = r.requester;
        @(posedge clk);
        while (!frame_req.ready)
            @(posedge clk);
        predicted = apply_frame_op(r);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            frame_req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((frame_req.valid && frame_req.ready) || (frame_rsp.valid && frame_rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        frame_rsp_t exp_rsp;
        if (rst_n && frame_rsp.valid && frame_rsp.ready)
        begin
            rsp_seen++;
            if (pending_rsp_q.size() == 0)
                flag_mismatch("response transaction with nothing expected");
            else
            begin
                exp_rsp = pending_rsp_q.pop_front();
                if (frame_rsp.status !== exp_rsp.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            frame_rsp.status, exp_rsp.status));
                if (frame_rsp.frame_out !== exp_rsp.frame_out)
                    flag_mismatch($sformatf("frame_out got %0d want %0d",
                                            frame_rsp.frame_out, exp_rsp.frame_out));
                if (frame_rsp.used_out !== exp_rsp.used_out)
                    flag_mismatch($sformatf("used_out got %0d want %0d",
                                            frame_rsp.used_out, exp_rsp.used_out));
                if (frame_rsp.page_out !== exp_rsp.page_out)
                    flag_mismatch($sformatf("page_out got %h want %h",
                                            frame_rsp.page_out, exp_rsp.page_out));
                if (frame_rsp.owner_out !== exp_rsp.owner_out)
                    flag_mismatch($sformatf("owner_out got %h want %h",
                                            frame_rsp.owner_out, exp_rsp.owner_out));
                if (frame_rsp.free_count !== exp_rsp.free_count)
                    flag_mismatch($sformatf("free_count got %0d want %0d",
                                            frame_rsp.free_count, exp_rsp.free_count));
            end
        end
    end

    // Response side: random back-pressure, calm stretches, and one long hold-off.
    initial
    begin
        int  stall_left;
        int  calm_left;
        bit  calm;
        bit  hold_done;
        stall_left      = 0;
        calm_left       = 0;
        calm            = 1'b0;
        hold_done       = 1'b0;
        frame_rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && rsp_seen >= HOLD_AFTER)
            begin
                frame_rsp.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (calm_left <= 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 200);
            end
            calm_left--;
            if (stall_left > 0)
            begin
                frame_rsp.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                frame_rsp.ready = 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        dir_row_t dir_table[$];
        frame_rsp_t none;
        bit no_gap;
        none           = '0;
        mismatch_count = 0;
        rsp_seen       = 0;
        shadow_victim  = 0;
        for (int i = 0; i < N_FRAMES; i++)
        begin
            shadow_used[i]  = 1'b0;
            shadow_page[i]  = '0;
            shadow_owner[i] = '0;
        end
        frame_req.valid     = 1'b0;
        frame_req.func      = FN_ALLOC;
        frame_req.frame     = '0;
        frame_req.page      = '0;
        frame_req.owner     = '0;
        frame_req.requester = '0;

        // Rows with a typed response are read straight off the table contents.
        dir_table.push_back(mk_row(mk_req(FN_COUNT, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 32)));
        dir_table.push_back(mk_row(mk_req(FN_QUERY, 31, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 31, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_VICTIM, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 1, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_ALLOC, 0, 16'hFFFF, 8'hFF, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_ALLOC, 31, 16'h0000, 8'h00, 8'hFF), 1, 1,
                                   mk_rsp(ST_OK, 1, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_QUERY, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 1, 16'hFFFF, 8'hFF, 0)));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 0, 0, 0, 8'h00), 1, 1,
                                   mk_rsp(ST_REFUSED, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 0, 0, 0, 8'hFF), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        // Release clears only the used bit; page and owner remain readable.
        dir_table.push_back(mk_row(mk_req(FN_QUERY, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 16'hFFFF, 8'hFF, 0)));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 5, 0, 0, 8'h12), 1, 1,
                                   mk_rsp(ST_OK, 5, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_MARK, 31, 16'hA5A5, 8'h5A, 0), 1, 1,
                                   mk_rsp(ST_OK, 31, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_QUERY, 31, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 31, 1, 16'hA5A5, 8'h5A, 0)));
        dir_table.push_back(mk_row(mk_req(FN_COUNT, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 30)));
        dir_table.push_back(mk_row(mk_req(FN_SPARE_6, 31, 16'hFFFF, 8'hFF, 8'hFF), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_SPARE_7, 31, 16'hFFFF, 8'hFF, 8'hFF), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_VICTIM, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 2, 0, 0, 0, 0)));
        // Fill every remaining frame, then ask for one more.
        dir_table.push_back(mk_row(mk_req(FN_ALLOC, 0, 16'h1234, 8'h33, 0), 30, 0, none));
        dir_table.push_back(mk_row(mk_req(FN_ALLOC, 0, 16'hFFFF, 8'hFF, 0), 1, 1,
                                   mk_rsp(ST_NOFREE, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_COUNT, 0, 0, 0, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_MARK, 0, 16'h0000, 8'h00, 0), 1, 1,
                                   mk_rsp(ST_OK, 0, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 1, 0, 0, 8'h01), 1, 1,
                                   mk_rsp(ST_REFUSED, 1, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 1, 0, 0, 8'h00), 1, 1,
                                   mk_rsp(ST_OK, 1, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_ALLOC, 0, 16'h0007, 8'h80, 0), 1, 1,
                                   mk_rsp(ST_OK, 1, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_QUERY, 1, 0, 0, 0), 1, 0, none));
        dir_table.push_back(mk_row(mk_req(FN_RELEASE, 31, 0, 0, 8'h5A), 1, 1,
                                   mk_rsp(ST_OK, 31, 0, 0, 0, 0)));
        dir_table.push_back(mk_row(mk_req(FN_COUNT, 0, 0, 0, 0), 1, 0, none));

        wait (rst_n === 1'b1);
        @(negedge clk);

        foreach (dir_table[k])
            repeat (dir_table[k].reps)
                send_frame_op(dir_table[k].req, dir_table[k].typed, dir_table[k].rsp, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_gap = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_frame_op(draw_frame_op(p % 3), 1'b0, none, no_gap);
            // Every so often the sender stops until the table has answered everything.
            if (p % 4 == 3)
            begin
                frame_req.valid = 1'b0;
                while (pending_rsp_q.size() != 0)
                    @(negedge clk);
            end
        end
        frame_req.valid = 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### physical_frame_table_unit.f
+incdir+sv
sv/pft_pkg.sv
sv/pft_ifs.sv
sv/pft_store.sv
sv/pft_scan.sv
sv/physical_frame_table_unit.sv
tb/sv/tb_physical_frame_table_unit.sv
